// ===== rtl/triple_average_balance_regulator_unit_defines.svh =====
// Assertion helpers used by the checker module of the regulator.
`ifndef TRIPLE_AVERAGE_BALANCE_REGULATOR_UNIT_DEFINES_SVH
`define TRIPLE_AVERAGE_BALANCE_REGULATOR_UNIT_DEFINES_SVH

// Concurrent check on the rising clock edge, switched off while reset is held.
`define TABR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tabr check failed");

// Same check with a caller supplied message.
`define TABR_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

// ===== rtl/tabr_pkg.sv =====
package tabr_pkg;

    localparam int FRAC_BITS = 15;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * Q_W;
    localparam int NARROW_W  = 14;
    localparam int ONE_INT   = 1 << FRAC_BITS;

    // Decimal constant in hundredths, rounded to the nearest fixed-point value.
    function automatic int cq(input int h);
        return (ONE_INT * h + 50) / 100;
    endfunction

    localparam logic [Q_W-1:0] Q_ONE         = Q_W'(ONE_INT);
    localparam logic [Q_W-1:0] Q_HALF        = Q_W'(ONE_INT / 2);
    localparam logic [Q_W-1:0] BAL_HIGH      = Q_W'(cq(5));
    localparam logic [Q_W-1:0] BAL_LOW       = Q_W'(cq(8));
    localparam logic [Q_W-1:0] STEP_MAX      = Q_W'(cq(2));
    localparam logic [Q_W-1:0] TEMPO_MIN     = Q_W'(cq(70));
    localparam logic [Q_W-1:0] BAL_BOOST_MAX = Q_W'(cq(15));
    localparam logic [Q_W-1:0] SOFT_MAX      = Q_W'(cq(30));
    localparam logic [Q_W-1:0] BOOST_MAX     = Q_W'(cq(35));
    localparam logic [Q_W-1:0] RELIEF_MAX    = Q_W'(cq(40));
    localparam logic [Q_W-1:0] CDELTA_MAX    = Q_W'(cq(20));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        STEP_IMP_OLD,
        STEP_IMP_NEW,
        STEP_OBS_OLD,
        STEP_OBS_NEW,
        STEP_CHO_OLD,
        STEP_CHO_NEW,
        STEP_SOFT,
        STEP_RELIEF
    } t_step;

    typedef enum logic [1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_GAMMA  = 2'd1,
        CFG_ENABLE = 2'd2
    } t_cfg_idx;

    function automatic logic [Q_W-1:0] unit_clamp(input logic [Q_W-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

endpackage

// ===== rtl/tabr_in_if.sv =====
interface tabr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] impulse_sample;
    logic [15:0] observation_sample;
    logic [15:0] choice_sample;

    modport source (
        output valid, impulse_sample, observation_sample, choice_sample,
        input  ready
    );
    modport sink (
        input  valid, impulse_sample, observation_sample, choice_sample,
        output ready
    );
endinterface

// ===== rtl/tabr_out_if.sv =====
interface tabr_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] tempo_factor;
    logic        [13:0] imp_boost;
    logic signed [13:0] cho_adjust;
    logic        [13:0] obs_relief;

    modport source (
        output valid, tempo_factor, imp_boost, cho_adjust, obs_relief,
        input  ready
    );
    modport sink (
        input  valid, tempo_factor, imp_boost, cho_adjust, obs_relief,
        output ready
    );
endinterface

// ===== rtl/triple_average_balance_regulator_unit.sv =====
// While enabled, an accepted item is worked through eight products on the single
// shared 16x16 multiplier before its result is loaded into the output registers;
// while disabled it goes straight to the output load. A new item is accepted only
// after the previous result has been loaded, and a stalled output holds the unit.
// Reset (synchronous, active low) clears the configuration registers, averages
// and run state; writing enable to 0 clears the averaging and run state as well.
module triple_average_balance_regulator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tabr_in_if.sink                         i_in,
    tabr_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import tabr_pkg::*;

    t_state r_state, n_state;
    t_step  r_step;

    logic [Q_W-1:0] r_alpha, r_gamma;
    logic           r_enable;

    logic [Q_W-1:0] r_ia, r_oa, r_ca, r_prev;
    logic           r_prev_valid;
    logic [1:0]     r_run;

    logic [Q_W-1:0] r_imp, r_obs, r_cho;
    logic [Q_W-1:0] r_blend, r_keep, r_g;
    logic           r_phase;
    logic           r_bypass;
    logic [PROD_W-1:0] r_acc;
    logic [Q_W-1:0] r_soft, r_relief;

    logic                       r_out_valid;
    logic [15:0]                r_tempo;
    logic [NARROW_W-1:0]        r_boost;
    logic signed [NARROW_W-1:0] r_cdelta;
    logic [NARROW_W-1:0]        r_relief_out;

    logic w_accept, w_load, w_last;

    // Input side clamping and stability detection.
    logic [Q_W-1:0]   w_imp_c, w_obs_c, w_cho_c, w_alpha_c;
    logic signed [Q_W:0] w_diff;
    logic [Q_W-1:0]   w_step_abs;
    logic [1:0]       w_run_new;

    assign w_imp_c   = unit_clamp(i_in.impulse_sample);
    assign w_obs_c   = unit_clamp(i_in.observation_sample);
    assign w_cho_c   = unit_clamp(i_in.choice_sample);
    assign w_alpha_c = unit_clamp(r_alpha);
    assign w_diff    = $signed({1'b0, w_obs_c}) - $signed({1'b0, r_prev});
    assign w_step_abs = w_diff[Q_W] ? Q_W'(-w_diff) : w_diff[Q_W-1:0];

    always_comb begin
        if (!r_prev_valid || w_step_abs > STEP_MAX) begin
            w_run_new = 2'd0;
        end else if (r_run < 2'd3) begin
            w_run_new = r_run + 2'd1;
        end else begin
            w_run_new = r_run;
        end
    end

    // Shared multiplier and its operand selection.
    logic [Q_W-1:0]    w_opa, w_opb;
    logic [PROD_W-1:0] w_prod, w_sum;
    logic [Q_W-1:0]    w_avg, w_prod_q;

    always_comb begin
        case (r_step)
            STEP_IMP_OLD: begin w_opa = r_keep;  w_opb = r_ia;  end
            STEP_IMP_NEW: begin w_opa = r_blend; w_opb = r_imp; end
            STEP_OBS_OLD: begin w_opa = r_keep;  w_opb = r_oa;  end
            STEP_OBS_NEW: begin w_opa = r_blend; w_opb = r_obs; end
            STEP_CHO_OLD: begin w_opa = r_keep;  w_opb = r_ca;  end
            STEP_CHO_NEW: begin w_opa = r_blend; w_opb = r_cho; end
            STEP_SOFT:    begin w_opa = r_g;     w_opb = Q_HALF + (r_ca >> 1); end
            default:      begin w_opa = r_g;     w_opb = Q_ONE - r_obs; end
        endcase
    end

    assign w_prod   = PROD_W'(w_opa) * PROD_W'(w_opb);
    assign w_sum    = r_acc + w_prod;
    assign w_avg    = w_sum[FRAC_BITS +: Q_W];
    assign w_prod_q = w_prod[FRAC_BITS +: Q_W];
    assign w_last   = (r_step == STEP_RELIEF);

    // Result assembly from the updated averages.
    logic signed [Q_W+1:0] w_bal, w_tempo_s, w_d, w_cd;
    logic [Q_W-1:0]        w_tempo, w_base, w_soft_l, w_boost, w_relief;
    logic [Q_W:0]          w_boost_sum;
    logic [Q_W+1:0]        w_neg;

    always_comb begin
        w_bal     = $signed({2'b00, r_ia}) - $signed({2'b00, r_oa});
        w_tempo   = Q_ONE;
        w_base    = '0;
        w_neg     = '0;
        w_tempo_s = $signed({2'b00, Q_ONE}) - (w_bal >>> 1);
        if (w_bal > $signed({2'b00, BAL_HIGH})) begin
            w_tempo = (w_tempo_s < $signed({2'b00, TEMPO_MIN})) ?
                      TEMPO_MIN : w_tempo_s[Q_W-1:0];
        end else if (w_bal < -$signed({2'b00, BAL_LOW})) begin
            w_neg  = (-w_bal) >> 2;
            w_base = (w_neg > {2'b00, BAL_BOOST_MAX}) ? BAL_BOOST_MAX : w_neg[Q_W-1:0];
        end

        w_soft_l    = (r_soft > SOFT_MAX) ? SOFT_MAX : r_soft;
        w_boost_sum = {1'b0, w_base} + (r_phase ? {1'b0, w_soft_l} : '0);
        w_boost     = (w_boost_sum > {1'b0, BOOST_MAX}) ? BOOST_MAX : w_boost_sum[Q_W-1:0];
        w_relief    = !r_phase ? '0 : ((r_relief > RELIEF_MAX) ? RELIEF_MAX : r_relief);

        // Negative offsets round toward minus infinity, as an arithmetic shift does.
        w_d = $signed({2'b00, r_ca}) - $signed({2'b00, Q_HALF});
        if (w_d < 0) begin
            w_cd = -$signed((-w_d + (Q_W+2)'(3)) >>> 2);
        end else begin
            w_cd = w_d >>> 2;
        end
        if (w_cd > $signed({2'b00, CDELTA_MAX})) begin
            w_cd = $signed({2'b00, CDELTA_MAX});
        end else if (w_cd < -$signed({2'b00, CDELTA_MAX})) begin
            w_cd = -$signed({2'b00, CDELTA_MAX});
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = r_enable ? ST_BUSY : ST_FINISH;
                end
            end
            ST_BUSY: begin
                if (w_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == ST_IDLE) && i_rst_n;
        w_accept   = i_in.valid && (r_state == ST_IDLE);
        w_load     = (r_state == ST_FINISH) && (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= STEP_IMP_OLD;
            r_alpha      <= '0;
            r_gamma      <= '0;
            r_enable     <= 1'b0;
            r_ia         <= '0;
            r_oa         <= '0;
            r_ca         <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_run        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ALPHA:  r_alpha <= i_cfg_data;
                    CFG_GAMMA:  r_gamma <= i_cfg_data;
                    CFG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_ia         <= '0;
                            r_oa         <= '0;
                            r_ca         <= '0;
                            r_prev       <= '0;
                            r_prev_valid <= 1'b0;
                            r_run        <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_step <= STEP_IMP_OLD;
                if (r_enable) begin
                    r_prev       <= w_obs_c;
                    r_prev_valid <= 1'b1;
                    r_run        <= (w_run_new == 2'd3) ? 2'd1 : w_run_new;
                end
            end else if (r_state == ST_BUSY) begin
                r_step <= t_step'(r_step + 3'd1);
                unique case (r_step)
                    STEP_IMP_NEW: r_ia <= w_avg;
                    STEP_OBS_NEW: r_oa <= w_avg;
                    STEP_CHO_NEW: r_ca <= w_avg;
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_imp    <= w_imp_c;
            r_obs    <= w_obs_c;
            r_cho    <= w_cho_c;
            r_blend  <= (w_alpha_c != '0) ? w_alpha_c : Q_HALF;
            r_keep   <= Q_ONE - ((w_alpha_c != '0) ? w_alpha_c : Q_HALF);
            r_g      <= unit_clamp(r_gamma);
            r_phase  <= (w_run_new == 2'd3);
            r_bypass <= !r_enable;
        end
        if (r_state == ST_BUSY) begin
            case (r_step) inside
                STEP_IMP_OLD, STEP_OBS_OLD, STEP_CHO_OLD: r_acc <= w_prod;
                STEP_SOFT:   r_soft   <= w_prod_q;
                STEP_RELIEF: r_relief <= w_prod_q;
                default: ;
            endcase
        end
        if (w_load) begin
            if (r_bypass) begin
                r_tempo      <= Q_ONE;
                r_boost      <= '0;
                r_cdelta     <= '0;
                r_relief_out <= '0;
            end else begin
                r_tempo      <= w_tempo;
                r_boost      <= w_boost[NARROW_W-1:0];
                r_cdelta     <= w_cd[NARROW_W-1:0];
                r_relief_out <= w_relief[NARROW_W-1:0];
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.tempo_factor = r_tempo;
    assign o_out.imp_boost    = r_boost;
    assign o_out.cho_adjust   = r_cdelta;
    assign o_out.obs_relief   = r_relief_out;

endmodule

// ===== rtl/tabr_checker.sv =====
`include "triple_average_balance_regulator_unit_defines.svh"

module tabr_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic        [15:0] i_tempo_factor,
    input  logic        [13:0] i_imp_boost,
    input  logic signed [13:0] i_cho_adjust,
    input  logic        [13:0] i_obs_relief
);
    import tabr_pkg::*;

    // An accepted item occupies the unit, so ready is low after the accepting edge.
    `TABR_ASSERT(a_busy_after_accept, (i_in_valid && i_in_ready) |=> !i_in_ready)

    `TABR_ASSERT_MSG(a_out_range,
        i_out_valid |-> (i_tempo_factor >= TEMPO_MIN && i_tempo_factor <= Q_ONE &&
        i_imp_boost <= NARROW_W'(BOOST_MAX) &&
        i_obs_relief <= NARROW_W'(RELIEF_MAX)), "result field out of range")

    `TABR_ASSERT_MSG(a_delta_range,
        i_out_valid |-> (i_cho_adjust <= $signed(NARROW_W'(CDELTA_MAX)) &&
        i_cho_adjust >= -$signed(NARROW_W'(CDELTA_MAX))), "choice delta out of range")

    `TABR_ASSERT(a_out_hold,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_tempo_factor) &&
        $stable(i_imp_boost) && $stable(i_cho_adjust) &&
        $stable(i_obs_relief)))

endmodule

bind triple_average_balance_regulator_unit tabr_checker u_tabr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_tempo_factor (o_out.tempo_factor),
    .i_imp_boost    (o_out.imp_boost),
    .i_cho_adjust   (o_out.cho_adjust),
    .i_obs_relief   (o_out.obs_relief)
);

// ===== dv/triple_average_balance_regulator_unit_test.sv =====
`timescale 1ns / 1ps

module triple_average_balance_regulator_unit_test;
    import tabr_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int END_CYCLES      = 30;
    localparam int PHASES          = 12;
    localparam int PHASE_ITEMS     = 120;

    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Fixed-point constants, Q1.15, rounded to the nearest step.
    localparam int     FRAC_SHIFT       = 15;
    localparam longint ONE_Q15          = 32768;
    localparam longint HALF_Q15         = 16384;
    localparam longint TEMPO_THRESH     = 1638;   // 0.05
    localparam longint BOOST_THRESH     = 2621;   // 0.08
    localparam longint STEP_LIMIT       = 655;    // 0.02
    localparam longint TEMPO_FLOOR      = 22938;  // 0.7
    localparam longint BAL_BOOST_CAP    = 4915;   // 0.15
    localparam longint STABLE_BOOST_CAP = 9830;   // 0.3
    localparam longint BOOST_CAP        = 11469;  // 0.35
    localparam longint RELIEF_CAP       = 13107;  // 0.4
    localparam longint DELTA_CAP        = 6554;   // 0.2

    typedef struct packed {
        logic [15:0] tempo;
        logic [13:0] boost;
        logic [13:0] delta;
        logic [13:0] relief;
    } t_regulation;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    tabr_in_if  in_ch();
    tabr_out_if out_ch();

    triple_average_balance_regulator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Predictor copy of the registers and the averaging state.
    logic [15:0] cfg_alpha;
    logic [15:0] cfg_gamma;
    logic        cfg_enable;
    longint      avg_impulse;
    longint      avg_observation;
    longint      avg_choice;
    longint      prev_obs_level;
    logic        observation_seen;
    int          steady_run;

    t_regulation pending_regulation[$];

    bit gap_in_enable    = 1'b1;
    bit stall_out_enable = 1'b1;
    int hold_off_request = 0;
    int walk_level       = 16384;

    int errors          = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int tempo_cuts      = 0;
    int balance_boosts  = 0;
    int stable_hits     = 0;
    int idle_count      = 0;

    function automatic longint to_unit(input logic [15:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : longint'(v);
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_regulator_state();
        avg_impulse      = 0;
        avg_observation  = 0;
        avg_choice       = 0;
        prev_obs_level   = 0;
        observation_seen = 1'b0;
        steady_run       = 0;
    endfunction

    // Advances the predicted state by one item and returns the expected result.
    function automatic t_regulation regulate(input logic [15:0] imp_in, obs_in, cho_in);
        t_regulation r;
        longint g, imp, obs, cho, blend, keep, bal, step, dev;
        longint tempo, boost, relief, delta;
        tempo  = ONE_Q15;
        boost  = 0;
        relief = 0;
        delta  = 0;
        if (cfg_enable) begin
            g     = to_unit(cfg_gamma);
            imp   = to_unit(imp_in);
            obs   = to_unit(obs_in);
            cho   = to_unit(cho_in);
            blend = (to_unit(cfg_alpha) > 0) ? to_unit(cfg_alpha) : HALF_Q15;
            keep  = ONE_Q15 - blend;

            avg_impulse     = (keep * avg_impulse + blend * imp) >>> FRAC_SHIFT;
            avg_observation = (keep * avg_observation + blend * obs) >>> FRAC_SHIFT;
            avg_choice      = (keep * avg_choice + blend * cho) >>> FRAC_SHIFT;

            bal = avg_impulse - avg_observation;
            if (bal > TEMPO_THRESH) begin
                tempo = sat(ONE_Q15 - (bal >>> 1), TEMPO_FLOOR, ONE_Q15);
                tempo_cuts++;
            end else if (bal < -BOOST_THRESH) begin
                boost = sat((-bal) >>> 2, 0, BAL_BOOST_CAP);
                balance_boosts++;
            end

            step = obs - prev_obs_level;
            if (step < 0) step = -step;
            if (!observation_seen || step > STEP_LIMIT) begin
                steady_run = 0;
            end else if (steady_run < 3) begin
                steady_run++;
            end
            prev_obs_level   = obs;
            observation_seen = 1'b1;

            // A stable run reaching three adds the gamma-scaled boost and relief and restarts at one.
            if (steady_run >= 3) begin
                boost += sat((g * (HALF_Q15 + (avg_choice >>> 1))) >>> FRAC_SHIFT, 0,
                             STABLE_BOOST_CAP);
                relief = sat((g * (ONE_Q15 - obs)) >>> FRAC_SHIFT, 0, RELIEF_CAP);
                steady_run = 1;
                stable_hits++;
            end
            boost = sat(boost, 0, BOOST_CAP);

            dev   = avg_choice - HALF_Q15;
            delta = (dev < 0) ? -(((-dev) + 3) >>> 2) : (dev >>> 2);
            delta = sat(delta, -DELTA_CAP, DELTA_CAP);
        end
        r.tempo  = tempo[15:0];
        r.boost  = boost[13:0];
        r.delta  = delta[13:0];
        r.relief = relief[13:0];
        return r;
    endfunction

    // Observation follows a random walk most of the time so that stable runs occur.
    function automatic void next_samples(output logic [15:0] imp, obs, cho);
        int m;
        int near;
        m = $urandom_range(0, 9);
        if (m < 7) begin
            if ($urandom_range(0, 1)) walk_level += int'($urandom_range(0, 700));
            else walk_level -= int'($urandom_range(0, 700));
        end else if (m == 7) begin
            walk_level = $urandom_range(0, 65535);
        end else begin
            walk_level = $urandom_range(32000, 34000);
        end
        walk_level = int'(sat(walk_level, 0, 65535));
        obs = 16'(walk_level);

        near = int'(sat(walk_level + int'($urandom_range(0, 10000)) - 5000, 0, 65535));
        case ($urandom_range(0, 3))
            0:       imp = 16'($urandom);
            1:       imp = 16'(near);
            default: imp = 16'($urandom_range(0, 32768));
        endcase
        cho = ($urandom_range(0, 9) < 3) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ALPHA: cfg_alpha = value;
            CFG_GAMMA: cfg_gamma = value;
            CFG_ENABLE: begin
                cfg_enable = value[0];
                if (!value[0]) clear_regulator_state();
            end
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Valid stays high after a transaction when the next item follows without a gap.
    task automatic send_sample(input logic [15:0] imp, obs, cho);
        int gap;
        gap = gap_in_enable ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid              <= 1'b1;
        in_ch.impulse_sample     <= imp;
        in_ch.observation_sample <= obs;
        in_ch.choice_sample      <= cho;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        pending_regulation.push_back(regulate(imp, obs, cho));
        samples_sent++;
    endtask

    task automatic send_random(input int count);
        logic [15:0] imp, obs, cho;
        repeat (count) begin
            next_samples(imp, obs, cho);
            send_sample(imp, obs, cho);
        end
    endtask

    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        while (pending_regulation.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_disabled_defaults();
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h8000, 16'h0000, 16'h8000);
        wait_results_done();
    endtask

    task automatic test_directed_cases();
        write_reg(CFG_ALPHA, 16'd0);
        write_reg(CFG_GAMMA, 16'd32768);
        write_reg(CFG_ENABLE, 16'd1);
        // Unchanged observation over four items reaches the stable phase.
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'hFFFF);
        send_sample(16'h8001, 16'h0000, 16'h8000);
        // A large observation jump restarts the run and drives the balance low.
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h4000);
        send_sample(16'h0000, 16'h8000 - 16'd655, 16'h4000);
        send_sample(16'h0000, 16'h8000 - 16'd1311, 16'h0000);
        wait_results_done();

        // Full weight makes each average equal to its sample; gamma above one.
        write_reg(CFG_ALPHA, 16'd32768);
        write_reg(CFG_GAMMA, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
        send_sample(16'h0000, 16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'hFFFF, 16'h0000);
        wait_results_done();

        write_reg(CFG_ALPHA, 16'hFFFF);
        send_sample(16'h7FFF, 16'h0001, 16'h2AAA);
        wait_results_done();

        // Smallest nonzero weights; enable rewritten while set, spare index written.
        write_reg(CFG_ALPHA, 16'd1);
        write_reg(CFG_GAMMA, 16'd1);
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_SPARE, 16'hA5A5);
        send_sample(16'h8000, 16'h0000, 16'h8000);
        send_sample(16'h8000, 16'h0000, 16'h8000);
        send_sample(16'h8000, 16'h0000, 16'h8000);
        wait_results_done();
    endtask

    task automatic test_output_hold_off();
        write_reg(CFG_ALPHA, 16'd8192);
        write_reg(CFG_GAMMA, 16'd24000);
        gap_in_enable    = 1'b0;
        stall_out_enable = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        send_random(14);
        wait_results_done();
        gap_in_enable    = 1'b1;
        stall_out_enable = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_random(20);
        wait_results_done();
        send_random(20);
        wait_results_done();
    endtask

    task automatic test_random_phases();
        logic [15:0] alpha_v;
        logic [15:0] gamma_v;
        for (int p = 0; p < PHASES; p++) begin
            case (p % 6)
                0:       alpha_v = 16'd0;
                1:       alpha_v = 16'd32768;
                2:       alpha_v = 16'd1;
                3:       alpha_v = 16'hFFFF;
                4:       alpha_v = 16'($urandom);
                default: alpha_v = 16'($urandom_range(0, 32768));
            endcase
            case (p % 4)
                0:       gamma_v = 16'd32768;
                1:       gamma_v = 16'd0;
                2:       gamma_v = 16'($urandom);
                default: gamma_v = 16'($urandom_range(0, 32768));
            endcase
            write_reg(CFG_ALPHA, alpha_v);
            write_reg(CFG_GAMMA, gamma_v);
            if (p == 5) begin
                write_reg(CFG_ENABLE, 16'd0);
            end else if (p == 6) begin
                write_reg(CFG_ENABLE, {15'($urandom), 1'b1});
            end else if (p % 4 == 0) begin
                write_reg(CFG_ENABLE, 16'd0);
                write_reg(CFG_ENABLE, 16'd1);
            end
            if (p == 7) write_reg(CFG_SPARE, 16'($urandom));

            gap_in_enable    = (p % 4 != 2);
            stall_out_enable = (p % 4 != 2) && (p % 4 != 1);
            send_random(PHASE_ITEMS);
            wait_results_done();
        end
        gap_in_enable    = 1'b1;
        stall_out_enable = 1'b1;
    endtask

    task automatic check_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_regulation want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_regulation.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tempo %0d",
                         $time, out_ch.tempo_factor);
                errors++;
            end else begin
                want = pending_regulation.pop_front();
                results_checked++;
                check_field("tempo factor", {1'b0, want.tempo}, {1'b0, out_ch.tempo_factor});
                check_field("impulse boost", {3'b0, want.boost}, {3'b0, out_ch.imp_boost});
                check_field("choice adjust", {{3{want.delta[13]}}, want.delta},
                            {{3{out_ch.cho_adjust[13]}}, out_ch.cho_adjust});
                check_field("observation relief", {3'b0, want.relief},
                            {3'b0, out_ch.obs_relief});
            end
        end
    end

    // The receiver draws a stall per result; a requested hold-off replaces one draw.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_request > 0) begin
                stall = hold_off_request;
                hold_off_request = 0;
            end else begin
                stall = stall_out_enable ? $urandom_range(0, 14) : 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_count <= 0;
        end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        i_rst_n                  <= 1'b0;
        i_cfg_we                 <= 1'b0;
        i_cfg_index              <= '0;
        i_cfg_data               <= '0;
        in_ch.valid              <= 1'b0;
        in_ch.impulse_sample     <= '0;
        in_ch.observation_sample <= '0;
        in_ch.choice_sample      <= '0;
        cfg_alpha  = '0;
        cfg_gamma  = '0;
        cfg_enable = 1'b0;
        clear_regulator_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_defaults();
        test_directed_cases();
        test_output_hold_off();
        test_sender_pause();
        test_random_phases();

        wait_results_done();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Run: %0d items, %0d results checked, %0d register writes, %0d mismatches.",
                 samples_sent, results_checked, cfg_writes, errors);
        $display("Seen: %0d tempo cuts, %0d balance boosts, %0d stable-phase boosts.",
                 tempo_cuts, balance_boosts, stable_hits);
        if (errors == 0 && pending_regulation.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
